### hdl/pvt_pkg.sv
// ----------------------------------------------------------------------------
// pvt_pkg
// Widths, register indexes and shared types of the perspective vertex
// transform pipeline.
// ----------------------------------------------------------------------------
package pvt_pkg;

   localparam int COORD_FRAC_BITS = 14;
   localparam int TRIG_FRAC_BITS  = 14;
   localparam int INV_FRAC_BITS   = 16;

   localparam int CRD_W  = 16;   // vertex coordinate
   localparam int TRIG_W = 16;   // cosine / sine register
   localparam int INV_W  = 16;   // inv_focal register
   localparam int HALF_W = 13;   // half_width / half_height register
   localparam int SCR_W  = 16;   // screen coordinate
   localparam int CSR_IDX_W = 3;

   // pitch rotation products and result
   localparam int P1_W   = CRD_W + TRIG_W;
   localparam int S1_W   = P1_W + 1;
   localparam int ROT1_W = S1_W - TRIG_FRAC_BITS;
   // yaw rotation products and result
   localparam int P2_W   = ROT1_W + TRIG_W;
   localparam int S2_W   = P2_W + 1;
   localparam int ROT2_W = S2_W - TRIG_FRAC_BITS;
   // depth times reciprocal focal distance
   localparam int ZP_W   = ROT2_W + INV_W + 1;
   localparam int ZS_W   = ZP_W - INV_FRAC_BITS;
   // perspective divisor w, wide enough for the unit constant and z term
   localparam int W_W    = ((COORD_FRAC_BITS > ZS_W - 1) ? COORD_FRAC_BITS : ZS_W - 1) + 2;
   localparam int DIV_W  = W_W - 1;     // magnitude of a positive w
   localparam int SUM_W  = W_W + 1;     // v + w
   localparam int NUM_W  = SUM_W + HALF_W + 1;
   localparam int QB     = SCR_W - 1;   // quotient bits below saturation
   localparam int REM0_W = NUM_W - QB;

   localparam logic signed [W_W-1:0] W_ONE = W_W'(2 ** COORD_FRAC_BITS);
   localparam logic [SCR_W-1:0] SCR_MAX = {1'b0, {(SCR_W-1){1'b1}}};
   localparam logic [SCR_W-1:0] SCR_MIN = {1'b1, {(SCR_W-1){1'b0}}};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PITCH_COS   = 3'd0,
      CSR_PITCH_SIN   = 3'd1,
      CSR_YAW_COS     = 3'd2,
      CSR_YAW_SIN     = 3'd3,
      CSR_INV_FOCAL   = 3'd4,
      CSR_HALF_WIDTH  = 3'd5,
      CSR_HALF_HEIGHT = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic signed [TRIG_W-1:0] pitch_cos;
      logic signed [TRIG_W-1:0] pitch_sin;
      logic signed [TRIG_W-1:0] yaw_cos;
      logic signed [TRIG_W-1:0] yaw_sin;
      logic [INV_W-1:0]         inv_focal;
      logic [HALF_W-1:0]        half_width;
      logic [HALF_W-1:0]        half_height;
   } cfg_type;

   typedef struct packed {
      logic                     valid;
      logic signed [ROT2_W-1:0] x2;
      logic signed [ROT1_W-1:0] y2;
      logic signed [ROT2_W-1:0] z2;
   } rot_type;

   typedef struct packed {
      logic                    valid;
      logic                    front;
      logic [DIV_W-1:0]        w;
      logic signed [NUM_W-1:0] num_x;
      logic signed [NUM_W-1:0] num_y;
   } div_in_type;

   typedef struct packed {
      logic             valid;
      logic             front;
      logic [SCR_W-1:0] screen_x;
      logic [SCR_W-1:0] screen_y;
   } div_out_type;

endpackage

### hdl/perspective_vertex_transform.sv
// ----------------------------------------------------------------------------
// perspective_vertex_transform
// Rotates a model vertex by pitch and yaw, applies perspective and maps it
// to saturated screen coordinates.
// ----------------------------------------------------------------------------
// One vertex enters per cycle while the pipe advances: four rotation stages,
// four perspective stages, then a divider that resolves one quotient bit per
// stage (15 stages plus abs, setup and output). The whole pipe advances
// together whenever the output register is empty or being taken, so a stalled
// result holds every stage in place. The user must write registers through
// csr_* only while no vertex is in flight; the block does not enforce it.
module perspective_vertex_transform
   import pvt_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // request: vertex_x [15:0], vertex_y [31:16], vertex_z [47:32]
   input  logic [3*CRD_W-1:0]   req_tdata,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // response: screen_x [15:0], screen_y [31:16]
   output logic [2*SCR_W-1:0]   rsp_tdata,
   // response: in_front [0]
   output logic                 rsp_tuser,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [TRIG_W-1:0]    csr_wdata
);

   cfg_type     cfg_ff;
   rot_type     rot;
   div_in_type  proj;
   div_out_type res;
   logic        en;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pitch_cos   <= TRIG_W'(16384);
         cfg_ff.pitch_sin   <= '0;
         cfg_ff.yaw_cos     <= TRIG_W'(16384);
         cfg_ff.yaw_sin     <= '0;
         cfg_ff.inv_focal   <= INV_W'(655);
         cfg_ff.half_width  <= HALF_W'(400);
         cfg_ff.half_height <= HALF_W'(400);
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_PITCH_COS:   cfg_ff.pitch_cos   <= csr_wdata;
            CSR_PITCH_SIN:   cfg_ff.pitch_sin   <= csr_wdata;
            CSR_YAW_COS:     cfg_ff.yaw_cos     <= csr_wdata;
            CSR_YAW_SIN:     cfg_ff.yaw_sin     <= csr_wdata;
            CSR_INV_FOCAL:   cfg_ff.inv_focal   <= csr_wdata;
            CSR_HALF_WIDTH:  cfg_ff.half_width  <= csr_wdata[HALF_W-1:0];
            CSR_HALF_HEIGHT: cfg_ff.half_height <= csr_wdata[HALF_W-1:0];
            default: ;
         endcase
      end
   end

   // advance when the output register is free or being drained
   assign en         = !res.valid || rsp_tready;
   assign req_tready = en;

   pvt_rotate u_rotate (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_tvalid),
      .in_x     (req_tdata[CRD_W-1:0]),
      .in_y     (req_tdata[2*CRD_W-1:CRD_W]),
      .in_z     (req_tdata[3*CRD_W-1:2*CRD_W]),
      .cfg      (cfg_ff),
      .out      (rot)
   );

   pvt_project u_project (
      .clock (clock),
      .reset (reset),
      .en    (en),
      .in    (rot),
      .cfg   (cfg_ff),
      .out   (proj)
   );

   pvt_divide u_divide (
      .clock (clock),
      .reset (reset),
      .en    (en),
      .in    (proj),
      .out   (res)
   );

   assign rsp_tvalid = res.valid;
   assign rsp_tdata  = {res.screen_y, res.screen_x};
   assign rsp_tuser  = res.front;

endmodule

### hdl/pvt_rotate.sv
// ----------------------------------------------------------------------------
// pvt_rotate
// Four-stage pitch then yaw rotation of one vertex per cycle while en is high.
// ----------------------------------------------------------------------------
module pvt_rotate
   import pvt_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  logic signed [CRD_W-1:0] in_x,
   input  logic signed [CRD_W-1:0] in_y,
   input  logic signed [CRD_W-1:0] in_z,
   input  cfg_type                 cfg,
   output rot_type                 out
);

   logic [3:0] v_ff;

   // stage 1: pitch products
   logic signed [CRD_W-1:0] x_s1_ff;
   logic signed [P1_W-1:0]  yc_ff, zs_ff, ys_ff, zc_ff;
   // stage 2: pitch sums
   logic signed [CRD_W-1:0]  x_s2_ff;
   logic signed [ROT1_W-1:0] y1_ff, z1_ff;
   logic signed [S1_W-1:0]   sy_in, sz_in;
   // stage 3: yaw products
   logic signed [ROT1_W-1:0] y1_s3_ff;
   logic signed [P2_W-1:0]   xc_ff, zys_ff, xs_ff, zyc_ff;
   // stage 4: yaw sums
   logic signed [ROT1_W-1:0] y2_ff;
   logic signed [ROT2_W-1:0] x2_ff, z2_ff;
   logic signed [S2_W-1:0]   sx2_in, sz2_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[2:0], in_valid};
      end
   end

   always_comb begin
      sy_in  = S1_W'(yc_ff) - S1_W'(zs_ff);
      sz_in  = S1_W'(ys_ff) + S1_W'(zc_ff);
      sx2_in = S2_W'(xc_ff) - S2_W'(zys_ff);
      sz2_in = S2_W'(xs_ff) + S2_W'(zyc_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_s1_ff  <= in_x;
         yc_ff    <= P1_W'(in_y) * P1_W'(cfg.pitch_cos);
         zs_ff    <= P1_W'(in_z) * P1_W'(cfg.pitch_sin);
         ys_ff    <= P1_W'(in_y) * P1_W'(cfg.pitch_sin);
         zc_ff    <= P1_W'(in_z) * P1_W'(cfg.pitch_cos);

         x_s2_ff  <= x_s1_ff;
         y1_ff    <= sy_in[S1_W-1:TRIG_FRAC_BITS];
         z1_ff    <= sz_in[S1_W-1:TRIG_FRAC_BITS];

         y1_s3_ff <= y1_ff;
         xc_ff    <= P2_W'(x_s2_ff) * P2_W'(cfg.yaw_cos);
         zys_ff   <= P2_W'(z1_ff) * P2_W'(cfg.yaw_sin);
         xs_ff    <= P2_W'(x_s2_ff) * P2_W'(cfg.yaw_sin);
         zyc_ff   <= P2_W'(z1_ff) * P2_W'(cfg.yaw_cos);

         y2_ff    <= y1_s3_ff;
         x2_ff    <= sx2_in[S2_W-1:TRIG_FRAC_BITS];
         z2_ff    <= sz2_in[S2_W-1:TRIG_FRAC_BITS];
      end
   end

   assign out.valid = v_ff[3];
   assign out.x2    = x2_ff;
   assign out.y2    = y2_ff;
   assign out.z2    = z2_ff;

endmodule

### hdl/pvt_project.sv
// ----------------------------------------------------------------------------
// pvt_project
// Four-stage perspective term: w from depth, then (v + w) * half size.
// ----------------------------------------------------------------------------
module pvt_project
   import pvt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       en,
   input  rot_type    in,
   input  cfg_type    cfg,
   output div_in_type out
);

   logic [3:0] v_ff;

   // stage 5
   logic signed [ROT2_W-1:0] x_s5_ff;
   logic signed [ROT1_W-1:0] y_s5_ff;
   logic signed [ZP_W-1:0]   zp_ff;
   // stage 6
   logic signed [ROT2_W-1:0] x_s6_ff;
   logic signed [ROT1_W-1:0] y_s6_ff;
   logic signed [W_W-1:0]    w_s6_ff;
   // stage 7
   logic signed [SUM_W-1:0]  sx_ff, sy_ff;
   logic signed [W_W-1:0]    w_s7_ff;
   logic                     front_s7_ff;
   // stage 8
   logic signed [NUM_W-1:0]  nx_ff, ny_ff;
   logic [DIV_W-1:0]         w_s8_ff;
   logic                     front_s8_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[2:0], in.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_s5_ff     <= in.x2;
         y_s5_ff     <= in.y2;
         zp_ff       <= ZP_W'(in.z2) * ZP_W'($signed({1'b0, cfg.inv_focal}));

         x_s6_ff     <= x_s5_ff;
         y_s6_ff     <= y_s5_ff;
         w_s6_ff     <= W_ONE - W_W'($signed(zp_ff[ZP_W-1:INV_FRAC_BITS]));

         sx_ff       <= SUM_W'(x_s6_ff) + SUM_W'(w_s6_ff);
         sy_ff       <= SUM_W'(y_s6_ff) + SUM_W'(w_s6_ff);
         w_s7_ff     <= w_s6_ff;
         front_s7_ff <= !w_s6_ff[W_W-1] && (w_s6_ff != '0);

         nx_ff       <= NUM_W'(sx_ff) * NUM_W'($signed({1'b0, cfg.half_width}));
         ny_ff       <= NUM_W'(sy_ff) * NUM_W'($signed({1'b0, cfg.half_height}));
         w_s8_ff     <= w_s7_ff[DIV_W-1:0];
         front_s8_ff <= front_s7_ff;
      end
   end

   assign out.valid = v_ff[3];
   assign out.front = front_s8_ff;
   assign out.w     = w_s8_ff;
   assign out.num_x = nx_ff;
   assign out.num_y = ny_ff;

endmodule

### hdl/pvt_divide.sv
// ----------------------------------------------------------------------------
// pvt_divide
// Pipelined restoring divider for both screen axes, one quotient bit per
// stage, with saturation and the final output register.
// ----------------------------------------------------------------------------
module pvt_divide
   import pvt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  div_in_type  in,
   output div_out_type out
);

   localparam int LANES = 2;
   localparam int DEPTH = QB + 3;   // abs, init, QB steps, output

   logic [DEPTH-1:0] v_ff;

   // abs stage
   logic [NUM_W-1:0] mag_ff  [LANES];
   logic             neg_a_ff [LANES];
   logic [DIV_W-1:0] w_a_ff;
   logic             front_a_ff;
   logic signed [NUM_W-1:0] num_in [LANES];

   // step stages, index 0 holds the initial remainder
   logic [DIV_W-1:0] rem_ff  [QB+1][LANES];
   logic [QB-1:0]    low_ff  [QB+1][LANES];
   logic [QB-1:0]    q_ff    [QB+1][LANES];
   logic             neg_ff  [QB+1][LANES];
   logic             ovf_ff  [QB+1][LANES];
   logic [DIV_W-1:0] w_ff    [QB+1];
   logic             front_ff[QB+1];

   logic [DIV_W:0]   trial   [1:QB][LANES];
   logic             take    [1:QB][LANES];
   logic [DIV_W-1:0] rem_in  [1:QB][LANES];

   logic [SCR_W-1:0] res_in  [LANES];
   logic [SCR_W-1:0] res_ff  [LANES];
   logic             front_o_ff;

   assign num_in[0] = in.num_x;
   assign num_in[1] = in.num_y;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[DEPTH-2:0], in.valid};
      end
   end

   always_comb begin
      for (int s = 1; s <= QB; s++) begin
         for (int l = 0; l < LANES; l++) begin
            trial[s][l]  = {rem_ff[s-1][l], low_ff[s-1][l][QB-1]};
            take[s][l]   = trial[s][l] >= {1'b0, w_ff[s-1]};
            rem_in[s][l] = take[s][l] ? DIV_W'(trial[s][l] - {1'b0, w_ff[s-1]})
                                      : trial[s][l][DIV_W-1:0];
         end
      end
   end

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         if (!front_ff[QB]) begin
            res_in[l] = '0;
         end else if (ovf_ff[QB][l]) begin
            res_in[l] = neg_ff[QB][l] ? SCR_MIN : SCR_MAX;
         end else if (neg_ff[QB][l]) begin
            res_in[l] = SCR_W'(-{1'b0, q_ff[QB][l]});
         end else begin
            res_in[l] = {1'b0, q_ff[QB][l]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         w_a_ff     <= in.w;
         front_a_ff <= in.front;
         for (int l = 0; l < LANES; l++) begin
            neg_a_ff[l] <= num_in[l][NUM_W-1];
            mag_ff[l]   <= num_in[l][NUM_W-1] ? NUM_W'(-num_in[l]) : NUM_W'(num_in[l]);
         end

         // quotient at or above full scale saturates; otherwise the top part
         // of the magnitude is already below w
         w_ff[0]     <= w_a_ff;
         front_ff[0] <= front_a_ff;
         for (int l = 0; l < LANES; l++) begin
            ovf_ff[0][l] <= mag_ff[l] >= NUM_W'({w_a_ff, {QB{1'b0}}});
            neg_ff[0][l] <= neg_a_ff[l];
            rem_ff[0][l] <= DIV_W'(mag_ff[l][NUM_W-1:QB]);
            low_ff[0][l] <= mag_ff[l][QB-1:0];
            q_ff[0][l]   <= '0;
         end

         for (int s = 1; s <= QB; s++) begin
            w_ff[s]     <= w_ff[s-1];
            front_ff[s] <= front_ff[s-1];
            for (int l = 0; l < LANES; l++) begin
               ovf_ff[s][l] <= ovf_ff[s-1][l];
               neg_ff[s][l] <= neg_ff[s-1][l];
               rem_ff[s][l] <= rem_in[s][l];
               low_ff[s][l] <= {low_ff[s-1][l][QB-2:0], 1'b0};
               q_ff[s][l]   <= {q_ff[s-1][l][QB-2:0], take[s][l]};
            end
         end

         front_o_ff <= front_ff[QB];
         for (int l = 0; l < LANES; l++) begin
            res_ff[l] <= res_in[l];
         end
      end
   end

   assign out.valid    = v_ff[DEPTH-1];
   assign out.front    = front_o_ff;
   assign out.screen_x = res_ff[0];
   assign out.screen_y = res_ff[1];

endmodule

### dv/pvt_projection_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvt_projection_checker
// Watches the register port and both stream channels of the perspective
// vertex transform. It keeps its own copy of the view registers, projects
// every accepted request and checks each result in order.
// ----------------------------------------------------------------------------
module pvt_projection_checker
   import pvt_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic [3*CRD_W-1:0]   req_tdata,
   input  logic                 req_tvalid,
   input  logic                 req_tready,
   input  logic [2*SCR_W-1:0]   rsp_tdata,
   input  logic                 rsp_tuser,
   input  logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [TRIG_W-1:0]    csr_wdata,
   output int                   projections_pending,
   output int                   mismatch_count
);

   typedef struct packed {
      logic signed [SCR_W-1:0] screen_x;
      logic signed [SCR_W-1:0] screen_y;
      logic                    in_front;
   } screen_point_t;

   cfg_type       view_cfg;
   screen_point_t projection_q[$];

   function automatic logic signed [SCR_W-1:0] clamp_screen(longint v);
      if (v > 32767) begin
         return SCR_MAX;
      end
      if (v < -32768) begin
         return SCR_MIN;
      end
      return v[SCR_W-1:0];
   endfunction

   function automatic screen_point_t project_vertex(logic signed [CRD_W-1:0] vx,
                                                    logic signed [CRD_W-1:0] vy,
                                                    logic signed [CRD_W-1:0] vz);
      longint        pc, ps, yc, ys, inv, hw, hh;
      longint        y1, z1, x2, z2, w;
      screen_point_t point;
      pc  = $signed(view_cfg.pitch_cos);
      ps  = $signed(view_cfg.pitch_sin);
      yc  = $signed(view_cfg.yaw_cos);
      ys  = $signed(view_cfg.yaw_sin);
      inv = view_cfg.inv_focal;
      hw  = view_cfg.half_width;
      hh  = view_cfg.half_height;
      // arithmetic right shift of a signed value is a floor division
      y1 = (vy * pc - vz * ps) >>> TRIG_FRAC_BITS;
      z1 = (vy * ps + vz * pc) >>> TRIG_FRAC_BITS;
      x2 = (vx * yc - z1 * ys) >>> TRIG_FRAC_BITS;
      z2 = (vx * ys + z1 * yc) >>> TRIG_FRAC_BITS;
      w  = (longint'(1) <<< COORD_FRAC_BITS) - ((z2 * inv) >>> INV_FRAC_BITS);
      point = '0;
      // at or behind the viewer: everything stays zero
      if (w > 0) begin
         point.screen_x = clamp_screen(((x2 + w) * hw) / w);
         point.screen_y = clamp_screen(((y1 + w) * hh) / w);
         point.in_front = 1'b1;
      end
      return point;
   endfunction

   task automatic compare_field(string field, logic signed [SCR_W-1:0] want,
                                logic signed [SCR_W-1:0] got);
      if (got !== want) begin
         mismatch_count++;
         $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin : monitor
      screen_point_t seen;
      screen_point_t want;
      if (reset) begin
         projection_q.delete();
         view_cfg = '{pitch_cos: 16384, pitch_sin: 0, yaw_cos: 16384, yaw_sin: 0,
                      inv_focal: 655, half_width: 400, half_height: 400};
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_PITCH_COS:   view_cfg.pitch_cos   = csr_wdata;
               CSR_PITCH_SIN:   view_cfg.pitch_sin   = csr_wdata;
               CSR_YAW_COS:     view_cfg.yaw_cos     = csr_wdata;
               CSR_YAW_SIN:     view_cfg.yaw_sin     = csr_wdata;
               CSR_INV_FOCAL:   view_cfg.inv_focal   = csr_wdata;
               CSR_HALF_WIDTH:  view_cfg.half_width  = csr_wdata[HALF_W-1:0];
               CSR_HALF_HEIGHT: view_cfg.half_height = csr_wdata[HALF_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            projection_q = {projection_q, project_vertex(req_tdata[CRD_W-1:0],
                                                         req_tdata[2*CRD_W-1:CRD_W],
                                                         req_tdata[3*CRD_W-1:2*CRD_W])};
         end
         if (rsp_tvalid && rsp_tready) begin
            seen.screen_x = rsp_tdata[SCR_W-1:0];
            seen.screen_y = rsp_tdata[2*SCR_W-1:SCR_W];
            seen.in_front = rsp_tuser;
            if (projection_q.size() == 0) begin
               mismatch_count++;
               $display("%0t: result with no request pending: expected none, got %0d %0d %b",
                        $time, seen.screen_x, seen.screen_y, seen.in_front);
            end else begin
               want = projection_q.pop_front();
               compare_field("screen_x", want.screen_x, seen.screen_x);
               compare_field("screen_y", want.screen_y, seen.screen_y);
               compare_field("in_front", want.in_front, seen.in_front);
            end
         end
      end
      projections_pending <= projection_q.size();
   end

endmodule

### dv/tb_perspective_vertex_transform.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_perspective_vertex_transform
// Drives vertices through the perspective vertex transform under several
// view settings, with random gaps on the request side and random stalls on
// the result side. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_perspective_vertex_transform;
   import pvt_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;
   localparam int LIMIT_CYCLES   = 200000;
   localparam int RANDOM_PHASES  = 12;
   localparam int PHASE_VERTICES = 90;
   localparam int CALM_PHASE     = 5;
   localparam int CALM_VERTICES  = 160;
   localparam int DRAIN_CYCLES   = 30;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic [3*CRD_W-1:0]   req_tdata  = '0;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [2*SCR_W-1:0]   rsp_tdata;
   logic                 rsp_tuser;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic                 csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index  = '0;
   logic [TRIG_W-1:0]    csr_wdata  = '0;

   int idle_pct    = 28;
   int cycle_count = 0;
   int projections_pending;
   int mismatch_count;

   perspective_vertex_transform DUT (.*);

   pvt_projection_checker checker_inst (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= idle_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("perspective_vertex_transform: mismatch");
         $finish;
      end
   end

   task automatic send_vertex(logic [CRD_W-1:0] x, logic [CRD_W-1:0] y,
                              logic [CRD_W-1:0] z);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {z, y, x};
      do @(posedge clock); while (!req_tready);
   endtask

   // drop valid and hold until every pending projection has come back
   task automatic wait_for_projections();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (projections_pending != 0);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [TRIG_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic load_view(logic [TRIG_W-1:0] pc, logic [TRIG_W-1:0] ps,
                            logic [TRIG_W-1:0] yc, logic [TRIG_W-1:0] ys,
                            logic [TRIG_W-1:0] inv, logic [TRIG_W-1:0] hw,
                            logic [TRIG_W-1:0] hh);
      write_reg(CSR_PITCH_COS, pc);
      write_reg(CSR_PITCH_SIN, ps);
      write_reg(CSR_YAW_COS, yc);
      write_reg(CSR_YAW_SIN, ys);
      write_reg(CSR_INV_FOCAL, inv);
      write_reg(CSR_HALF_WIDTH, hw);
      write_reg(CSR_HALF_HEIGHT, hh);
      // an index past the list must leave every register alone
      write_reg(CSR_UNUSED, TRIG_W'($urandom));
      csr_we <= 1'b0;
   endtask

   function automatic logic [TRIG_W-1:0] random_trig();
      case ($urandom_range(0, 9))
         0: return -16'sd16384;
         1: return 16'sd16384;
         2: return '0;
         3: return TRIG_W'($urandom);
         default: return TRIG_W'($urandom_range(0, 32768) - 16384);
      endcase
   endfunction

   function automatic logic [TRIG_W-1:0] random_inv();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return 16'hFFFF;
         2: return 16'd655;
         3, 4: return TRIG_W'($urandom_range(0, 65535));
         default: return TRIG_W'($urandom_range(0, 4000));
      endcase
   endfunction

   function automatic logic [TRIG_W-1:0] random_half();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return 16'd4096;
         2: return TRIG_W'($urandom);
         default: return TRIG_W'($urandom_range(1, 800));
      endcase
   endfunction

   function automatic logic [CRD_W-1:0] random_coord();
      case ($urandom_range(0, 9))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2, 3, 4: return CRD_W'($urandom);
         default: return CRD_W'($urandom_range(0, 32768) - 16384);
      endcase
   endfunction

   initial begin
      int vertices;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset view: identity rotation, distant camera
      send_vertex(16'sd0, 16'sd0, 16'sd0);
      send_vertex(16'sd32767, 16'sd32767, 16'sd32767);
      send_vertex(-16'sd32768, -16'sd32768, -16'sd32768);
      send_vertex(16'sd32767, -16'sd32768, 16'sd0);
      send_vertex(-16'sd32768, 16'sd32767, -16'sd32768);
      send_vertex(16'sd0, 16'sd0, 16'sd32767);
      wait_for_projections();

      // near camera: w of one, zero and minus one, saturated screen values
      load_view(16'sd16384, 16'sd0, 16'sd16384, 16'sd0, 16'hFFFF, 16'd4096, 16'd4096);
      send_vertex(16'sd100, -16'sd100, 16'sd16384);
      send_vertex(16'sd32767, -16'sd32768, 16'sd16384);
      send_vertex(16'sd5, 16'sd5, 16'sd16385);
      send_vertex(16'sd5, 16'sd5, 16'sd16386);
      send_vertex(-16'sd32768, 16'sd32767, -16'sd32768);
      wait_for_projections();

      // negative trig extremes, orthographic, zero screen size
      load_view(-16'sd16384, 16'sd16384, 16'sd0, -16'sd16384, 16'd0, 16'd0, 16'd0);
      send_vertex(16'sd32767, 16'sd32767, -16'sd32768);
      send_vertex(-16'sd32768, 16'sd1234, 16'sd32767);
      send_vertex(16'sd0, -16'sd1, 16'sd1);
      wait_for_projections();

      // register patterns outside the stated ranges
      load_view(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'd32768, 16'hFFFF, 16'hE000);
      send_vertex(16'sd16384, -16'sd16384, 16'sd8192);
      send_vertex(-16'sd32768, -16'sd32768, 16'sd32767);
      send_vertex(16'sd32767, 16'sd0, -16'sd32768);
      wait_for_projections();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         idle_pct = (phase == CALM_PHASE) ? 0 : 28;
         vertices = (phase == CALM_PHASE) ? CALM_VERTICES : PHASE_VERTICES;
         load_view(random_trig(), random_trig(), random_trig(), random_trig(),
                   random_inv(), random_half(), random_half());
         for (int n = 0; n < vertices; n++) begin
            send_vertex(random_coord(), random_coord(), random_coord());
         end
         wait_for_projections();
      end

      idle_pct = 28;
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("perspective_vertex_transform: match");
      end else begin
         $display("perspective_vertex_transform: mismatch");
      end
      $finish;
   end

endmodule
